>>> src/iufhg_pkg.sv
package iufhg_pkg;

    localparam int MTU_W   = 14;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int ID_W    = 16;
    localparam int PLEN_W  = 14;
    localparam int LEN_W   = 15;
    localparam int CAP_W   = MTU_W + 4;
    localparam int OFF_W   = 11;
    localparam int CSUM_W  = 16;
    localparam int SUM_W   = 20;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 104;

    localparam logic [MTU_W-1:0] MTU_MIN   = MTU_W'(576);
    localparam logic [MTU_W-1:0] MTU_MAX   = MTU_W'(9216);
    localparam logic [MTU_W-1:0] MTU_RESET = MTU_W'(1500);
    localparam logic [MTU_W-1:0] IP_HDR    = MTU_W'(20);
    localparam logic [LEN_W-1:0] UDP_HDR   = LEN_W'(8);
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(8192);
    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] TTL_PROTO   = 16'hFF11;

    localparam logic [CIDX_W-1:0] CFG_LINK_MTU = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_SRC_ADDR = CIDX_W'(1);

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [MTU_W-1:0]  maxlen;
        logic [LEN_W-1:0]  udp_len;
        logic [SUM_W-1:0]  sum_base;
        logic [PORT_W-1:0] dst_port;
        logic [PORT_W-1:0] src_port;
    } t_desc;

endpackage

>>> src/iufhg_front.sv
module iufhg_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_q_full,
    input  logic [iufhg_pkg::PLEN_W-1:0]        i_payload_length,
    input  logic [iufhg_pkg::ADDR_W-1:0]        i_dest_address,
    input  logic [iufhg_pkg::PORT_W-1:0]        i_dest_port,
    input  logic [iufhg_pkg::PORT_W-1:0]        i_local_port,
    input  logic                                i_cfg_we,
    input  logic [iufhg_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [iufhg_pkg::CFG_W-1:0]         i_cfg_wdata,
    output logic                                o_push,
    output iufhg_pkg::t_desc                    o_desc
);

    logic [iufhg_pkg::MTU_W-1:0]  r_mtu;
    logic [iufhg_pkg::ADDR_W-1:0] r_src_addr;
    logic [iufhg_pkg::ID_W-1:0]   r_ident;

    logic [iufhg_pkg::MTU_W-1:0]  mtu_c;
    logic [iufhg_pkg::MTU_W-1:0]  mtu_less;
    logic [iufhg_pkg::MTU_W-1:0]  maxlen;
    logic [iufhg_pkg::CAP_W-1:0]  cap;
    logic [iufhg_pkg::LEN_W-1:0]  pay_c;
    logic [iufhg_pkg::LEN_W-1:0]  pay_cap;

    assign o_push = i_valid && !i_q_full;

    always_comb begin
        priority if (r_mtu < iufhg_pkg::MTU_MIN) begin
            mtu_c = iufhg_pkg::MTU_MIN;
        end else if (r_mtu > iufhg_pkg::MTU_MAX) begin
            mtu_c = iufhg_pkg::MTU_MAX;
        end else begin
            mtu_c = r_mtu;
        end
        mtu_less = mtu_c - iufhg_pkg::IP_HDR;
        maxlen   = {mtu_less[iufhg_pkg::MTU_W-1:3], 3'b000};
        cap      = {maxlen, 4'b0000} - iufhg_pkg::CAP_W'(iufhg_pkg::UDP_HDR);

        pay_c = iufhg_pkg::LEN_W'(i_payload_length);
        if (pay_c > iufhg_pkg::MAX_PAYLOAD) begin
            pay_c = iufhg_pkg::MAX_PAYLOAD;
        end
        pay_cap = pay_c;
        if (iufhg_pkg::CAP_W'(pay_c) > cap) begin
            pay_cap = cap[iufhg_pkg::LEN_W-1:0];
        end

        o_desc.ident    = r_ident;
        o_desc.maxlen   = maxlen;
        o_desc.udp_len  = pay_cap + iufhg_pkg::UDP_HDR;
        o_desc.sum_base = iufhg_pkg::SUM_W'(iufhg_pkg::VER_IHL_TOS)
                        + iufhg_pkg::SUM_W'(iufhg_pkg::TTL_PROTO)
                        + iufhg_pkg::SUM_W'(r_ident)
                        + iufhg_pkg::SUM_W'(r_src_addr[31:16])
                        + iufhg_pkg::SUM_W'(r_src_addr[15:0])
                        + iufhg_pkg::SUM_W'(i_dest_address[31:16])
                        + iufhg_pkg::SUM_W'(i_dest_address[15:0]);
        o_desc.dst_port = i_dest_port;
        o_desc.src_port = i_local_port;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu      <= iufhg_pkg::MTU_RESET;
            r_src_addr <= '0;
            r_ident    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == iufhg_pkg::CFG_LINK_MTU) begin
                r_mtu <= i_cfg_wdata[iufhg_pkg::MTU_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == iufhg_pkg::CFG_SRC_ADDR) begin
                r_src_addr <= i_cfg_wdata[iufhg_pkg::ADDR_W-1:0];
            end
            if (o_push) begin
                r_ident <= r_ident + 1'b1;
            end
        end
    end

endmodule

>>> src/iufhg_queue.sv
module iufhg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  iufhg_pkg::t_desc  i_desc,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output iufhg_pkg::t_desc  o_desc
);

    iufhg_pkg::t_desc                r_mem [iufhg_pkg::QDEPTH];
    logic [iufhg_pkg::QPTR_W-1:0]    r_wr;
    logic [iufhg_pkg::QPTR_W-1:0]    r_rd;
    logic [iufhg_pkg::QPTR_W:0]      r_cnt;

    assign o_full  = (r_cnt == (iufhg_pkg::QPTR_W+1)'(iufhg_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/iufhg_back.sv
module iufhg_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  iufhg_pkg::t_desc                    i_desc,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [iufhg_pkg::OUT_W-1:0]         o_data,
    output logic                                o_last
);

    logic                            r_busy;
    logic                            r_first;
    iufhg_pkg::t_desc                r_desc;
    logic [iufhg_pkg::LEN_W-1:0]     r_rem;
    logic [iufhg_pkg::LEN_W-1:0]     r_off;
    logic                            r_ovalid;
    logic [iufhg_pkg::OUT_W-1:0]     r_odata;
    logic                            r_olast;

    logic                            step;
    logic                            last;
    logic [iufhg_pkg::MTU_W-1:0]     cur;
    logic [iufhg_pkg::MTU_W-1:0]     tlen;
    logic [15:0]                     offw;
    logic [iufhg_pkg::SUM_W-1:0]     sum;
    logic [16:0]                     fold1;
    logic [16:0]                     fold2;
    logic [iufhg_pkg::CSUM_W-1:0]    csum;
    logic [iufhg_pkg::OUT_W-1:0]     n_odata;

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_pop   = !r_busy && i_q_valid;
    assign step    = r_busy && (!r_ovalid || i_ready);

    always_comb begin
        last  = (r_rem <= iufhg_pkg::LEN_W'(r_desc.maxlen));
        cur   = last ? r_rem[iufhg_pkg::MTU_W-1:0] : r_desc.maxlen;
        tlen  = cur + iufhg_pkg::IP_HDR;
        offw  = {2'b00, !last, 1'b0, r_off[iufhg_pkg::LEN_W-1:3]};
        sum   = r_desc.sum_base + iufhg_pkg::SUM_W'(tlen) + iufhg_pkg::SUM_W'(offw);
        fold1 = 17'(sum[15:0]) + 17'(sum[iufhg_pkg::SUM_W-1:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
        csum  = ~fold2[15:0];
        n_odata = {
            r_first ? r_desc.dst_port : iufhg_pkg::PORT_W'(0),
            r_first ? r_desc.src_port : iufhg_pkg::PORT_W'(0),
            r_first ? r_desc.udp_len[13:0] : 14'd0,
            csum,
            !last,
            r_off[iufhg_pkg::OFF_W+2:3],
            tlen,
            r_desc.ident
        };
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (step) begin
            r_odata <= n_odata;
            r_olast <= last;
        end
        if (o_pop) begin
            r_rem <= i_desc.udp_len;
            r_off <= '0;
        end else if (step) begin
            r_rem <= r_rem - iufhg_pkg::LEN_W'(r_desc.maxlen);
            r_off <= r_off + iufhg_pkg::LEN_W'(r_desc.maxlen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
            end else if (step) begin
                r_first <= 1'b0;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

>>> src/ipv4_udp_fragment_header_gen.sv
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_tvalid / s_tready  | s_tdata: one datagram descriptor
// m_       | out       | m_tvalid / m_tready  | m_tdata + m_tlast: one fragment header
// cfg      | in        | i_cfg_we             | i_cfg_index, i_cfg_wdata
//
// A datagram is classified combinationally and queued (two entries); the back end then
// loads it from the queue and emits one fragment header per cycle while m_tready does
// not stall it, taking the next datagram only once its last header has been issued.
// Reset is synchronous and active low; it clears the queue, the identification
// counter and the output valid flag, and restores the MTU to 1500.
// Either side may stall: the queue and the output register decouple them.
module ipv4_udp_fragment_header_gen (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // payload_length, dest_address, dest_port, local_port, zero padding
    input  logic [iufhg_pkg::IN_W-1:0]          s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ident, total_length, frag_offset, more_fragments, header_checksum,
    // udp_length, src_port_out, dst_port_out
    output logic [iufhg_pkg::OUT_W-1:0]         m_tdata,
    output logic                                m_tlast,
    input  logic                                i_cfg_we,
    input  logic [iufhg_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [iufhg_pkg::CFG_W-1:0]         i_cfg_wdata
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    iufhg_pkg::t_desc front_desc;
    iufhg_pkg::t_desc head_desc;

    assign s_tready = !q_full;

    iufhg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_tvalid),
        .i_q_full         (q_full),
        .i_payload_length (s_tdata[13:0]),
        .i_dest_address   (s_tdata[45:14]),
        .i_dest_port      (s_tdata[61:46]),
        .i_local_port     (s_tdata[77:62]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_push           (push),
        .o_desc           (front_desc)
    );

    iufhg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (front_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    iufhg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (head_desc),
        .o_pop     (pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_data    (m_tdata),
        .o_last    (m_tlast)
    );

endmodule
